[rtl/blmos_pkg.sv]
// Shared types, codes and the control program of the LED matrix object scanner.
// Used by blmos_sequencer and bicolor_led_matrix_object_scanner; depends on nothing.
`timescale 1ns / 1ps

package blmos_pkg;

  // Command codes carried in the input tuser
  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_MOVE = 2'd1;
  localparam logic [1:0] CMD_ZONE = 2'd2;
  localparam logic [1:0] CMD_NOP  = 2'd3;

  // Phase codes reported with each result item
  localparam logic [2:0] PH_BOOT  = 3'd0;
  localparam logic [2:0] PH_INIT  = 3'd1;
  localparam logic [2:0] PH_RED   = 3'd2;
  localparam logic [2:0] PH_PAUSE = 3'd3;
  localparam logic [2:0] PH_GREEN = 3'd4;

  // Object groups shown in the red and green half of each column
  localparam logic [15:0] RED_MASK   = 16'h01FF;
  localparam logic [15:0] GREEN_MASK = 16'h3E00;

  localparam int FIELDERS = 9;

  // Scan phase register, one-hot
  typedef enum logic [4:0] {
    ST_BOOT  = 5'b00001,
    ST_INIT  = 5'b00010,
    ST_RED   = 5'b00100,
    ST_PAUSE = 5'b01000,
    ST_GREEN = 5'b10000
  } scan_state_t;

  // Datapath operation of one control step
  typedef enum logic [3:0] {
    ACT_NOP,
    ACT_ACCEPT,
    ACT_ZONE,
    ACT_RD_OLD,
    ACT_WR_OLD,
    ACT_RD_NEW,
    ACT_WR_NEW,
    ACT_PHASE,
    ACT_RD_SCAN,
    ACT_ACC,
    ACT_RD_FIELD,
    ACT_WR_FIELD,
    ACT_EMIT
  } act_t;

  // Jump condition of one control step
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_IS_TICK,
    C_IS_MOVE,
    C_MOVE_SKIP,
    C_PH_INIT,
    C_PH_PAUSE,
    C_CNT_MORE,
    C_FIELD_MORE,
    C_OUT_FULL
  } cond_t;

  localparam int STEP_W = 5;
  typedef logic [STEP_W-1:0] step_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    step_t target;
  } ctrl_word_t;

  // Status from the datapath that the jump conditions test
  typedef struct packed {
    logic no_input;
    logic is_tick;
    logic is_move;
    logic move_skip;
    logic ph_init;
    logic ph_pause;
    logic cnt_more;
    logic field_more;
    logic out_full;
  } cond_flags_t;

  // Program entry points
  localparam step_t S_FETCH = 5'd0;
  localparam step_t S_MOVE  = 5'd4;
  localparam step_t S_TICK  = 5'd8;
  localparam step_t S_SCAN  = 5'd11;
  localparam step_t S_FIELD = 5'd14;
  localparam step_t S_EMIT  = 5'd16;
  localparam int    PROG_LEN = 18;

  // Control program
  function automatic ctrl_word_t ucode(input step_t step);
    ctrl_word_t w;
    case (step)
      5'd0:    w = '{ACT_ACCEPT,   C_NO_INPUT,   S_FETCH};
      5'd1:    w = '{ACT_NOP,      C_IS_TICK,    S_TICK};
      5'd2:    w = '{ACT_NOP,      C_IS_MOVE,    S_MOVE};
      5'd3:    w = '{ACT_ZONE,     C_ALWAYS,     S_FETCH};
      5'd4:    w = '{ACT_RD_OLD,   C_MOVE_SKIP,  S_FETCH};
      5'd5:    w = '{ACT_WR_OLD,   C_NEVER,      S_FETCH};
      5'd6:    w = '{ACT_RD_NEW,   C_NEVER,      S_FETCH};
      5'd7:    w = '{ACT_WR_NEW,   C_ALWAYS,     S_FETCH};
      5'd8:    w = '{ACT_PHASE,    C_NEVER,      S_FETCH};
      5'd9:    w = '{ACT_NOP,      C_PH_INIT,    S_FIELD};
      5'd10:   w = '{ACT_NOP,      C_PH_PAUSE,   S_EMIT};
      5'd11:   w = '{ACT_RD_SCAN,  C_NEVER,      S_FETCH};
      5'd12:   w = '{ACT_ACC,      C_CNT_MORE,   S_SCAN};
      5'd13:   w = '{ACT_NOP,      C_ALWAYS,     S_EMIT};
      5'd14:   w = '{ACT_RD_FIELD, C_NEVER,      S_FETCH};
      5'd15:   w = '{ACT_WR_FIELD, C_FIELD_MORE, S_FIELD};
      5'd16:   w = '{ACT_EMIT,     C_OUT_FULL,   S_EMIT};
      5'd17:   w = '{ACT_NOP,      C_ALWAYS,     S_FETCH};
      default: w = '{ACT_NOP,      C_ALWAYS,     S_FETCH};
    endcase
    return w;
  endfunction

  // Home cells of the nine fielders
  function automatic logic [3:0] fielder_col(input logic [3:0] k);
    logic [3:0] c;
    case (k)
      4'd0:    c = 4'd2;
      4'd1:    c = 4'd2;
      4'd2:    c = 4'd4;
      4'd3:    c = 4'd2;
      4'd4:    c = 4'd0;
      4'd5:    c = 4'd1;
      4'd6:    c = 4'd0;
      4'd7:    c = 4'd2;
      4'd8:    c = 4'd4;
      default: c = 4'd0;
    endcase
    return c;
  endfunction

  function automatic logic [3:0] fielder_row(input logic [3:0] k);
    logic [3:0] r;
    case (k)
      4'd0:    r = 4'd6;
      4'd1:    r = 4'd12;
      4'd2:    r = 4'd4;
      4'd3:    r = 4'd3;
      4'd4:    r = 4'd4;
      4'd5:    r = 4'd3;
      4'd6:    r = 4'd1;
      4'd7:    r = 4'd1;
      4'd8:    r = 4'd1;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] phase_code(input scan_state_t s);
    logic [2:0] p;
    case (s)
      ST_INIT:  p = PH_INIT;
      ST_RED:   p = PH_RED;
      ST_PAUSE: p = PH_PAUSE;
      ST_GREEN: p = PH_GREEN;
      default:  p = PH_BOOT;
    endcase
    return p;
  endfunction

endpackage

[rtl/blmos_cell_mem.sv]
// Cell map memory: one word of object bits per field cell, registered read.
// Per-entry valid flags make unwritten cells read as zero after reset. No package use.
`timescale 1ns / 1ps

module blmos_cell_mem #(
  parameter int CELLS = 65,
  parameter int AW    = 7,
  parameter int WIDTH = 14
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata
);

  logic [WIDTH-1:0] mem [CELLS];
  logic [CELLS-1:0] valid;

  // Mark written cells; reset clears the whole map at once
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, unwritten cells read as empty
  always_ff @(posedge clk) begin
    rdata <= valid[raddr] ? mem[raddr] : '0;
  end

endmodule

[rtl/blmos_sequencer.sv]
// Step counter and control store of the scanner: fetches one control word per
// cycle and takes conditional jumps on datapath status. Uses blmos_pkg.
`timescale 1ns / 1ps

module blmos_sequencer (
  input  logic                   clk,
  input  logic                   rst,
  input  blmos_pkg::cond_flags_t flags,
  output blmos_pkg::ctrl_word_t  ctrl
);

  blmos_pkg::step_t step;
  blmos_pkg::step_t step_next;
  logic             jump;

  assign ctrl = blmos_pkg::ucode(step);

  // Evaluate the jump condition of the current step
  always_comb begin
    case (ctrl.cond)
      blmos_pkg::C_NEVER:      jump = 1'b0;
      blmos_pkg::C_ALWAYS:     jump = 1'b1;
      blmos_pkg::C_NO_INPUT:   jump = flags.no_input;
      blmos_pkg::C_IS_TICK:    jump = flags.is_tick;
      blmos_pkg::C_IS_MOVE:    jump = flags.is_move;
      blmos_pkg::C_MOVE_SKIP:  jump = flags.move_skip;
      blmos_pkg::C_PH_INIT:    jump = flags.ph_init;
      blmos_pkg::C_PH_PAUSE:   jump = flags.ph_pause;
      blmos_pkg::C_CNT_MORE:   jump = flags.cnt_more;
      blmos_pkg::C_FIELD_MORE: jump = flags.field_more;
      blmos_pkg::C_OUT_FULL:   jump = flags.out_full;
      default:                 jump = 1'b1;
    endcase
    step_next = jump ? ctrl.target : step + 1'b1;
  end

  // Advance the step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= blmos_pkg::S_FETCH;
    end else begin
      step <= step_next;
    end
  end

  // The program never leaves its table
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    step < blmos_pkg::STEP_W'(blmos_pkg::PROG_LEN))
    else $error("sequencer step outside program");

endmodule

[rtl/bicolor_led_matrix_object_scanner.sv]
// Top level of the bicolor LED matrix object scanner: command decode, cell map
// datapath and result register. Uses blmos_pkg, blmos_sequencer, blmos_cell_mem.
`timescale 1ns / 1ps
//
// Usage:
//   Commands enter on the s_ channel: s_tuser holds the command (tick, move
//   object, set zone LED, ignored), s_tdata the object, column, row and
//   duration fields. Moves and zone writes update internal state and return
//   nothing. Each tick advances the scan phase and returns one item on the
//   m_ channel with the column, row and zone words of that phase.
// Sequence:
//   A command is taken only while the control program waits at its fetch
//   step. A move that is ignored or leaves the location unchanged ends after
//   reading the old cell; one that changes the location also clears it and,
//   for nonzero durations, marks the new cell. A tick in the red pause goes
//   straight to its emit step; in red and green phases the program reads each
//   cell of the scanned column through the cell memory, and the initialize
//   tick writes the nine fielder cells one after another.
// Reset: all cells empty, all objects at column 0 row 0, scan in boot,
//   column 0, zone LED unlit. Reset is immediate, no clearing pass.
// Stall: a finished result waits in the output register; the next command
//   is still taken, and a following tick waits at its emit step until the
//   receiver takes the waiting item.

module bicolor_led_matrix_object_scanner #(
  parameter int COLUMNS = 5,
  parameter int ROWS    = 13,
  parameter int OBJECTS = 14
) (
  input  logic        clk,
  input  logic        rst,
  // input command items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // object_id[3:0], column[7:4], row[11:8], durations[19:12]
  input  logic [1:0]  s_tuser,   // command[1:0]
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  // field_green_cols[4:0], field_red_cols[9:5], field_rows[22:10],
  // zone_green_cols[30:23], zone_red_cols[38:31], zone_rows[46:39], latch_strobe[47]
  output logic [47:0] m_tdata,
  // field_written[0], zone_written[1], phase[4:2]
  output logic [4:0]  m_tuser
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int OW    = $clog2(OBJECTS);

  localparam logic [OBJECTS-1:0] RED_SEL   = blmos_pkg::RED_MASK[OBJECTS-1:0];
  localparam logic [OBJECTS-1:0] GREEN_SEL = blmos_pkg::GREEN_MASK[OBJECTS-1:0];

  blmos_pkg::ctrl_word_t  ctrl;
  blmos_pkg::cond_flags_t flags;

  // latched command
  logic [1:0] cmd;
  logic [3:0] obj;
  logic [3:0] col;
  logic [3:0] row;
  logic [7:0] dur;

  // state
  logic [7:0]             loc [OBJECTS];
  blmos_pkg::scan_state_t scan_state;
  blmos_pkg::scan_state_t scan_state_next;
  logic [2:0]             scan_column;
  logic [8:0]             zone_cell;
  logic [3:0]             cnt;
  logic [ROWS-1:0]        acc;

  // memory port
  logic [AW-1:0]      mem_raddr;
  logic [OBJECTS-1:0] mem_rdata;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [OBJECTS-1:0] mem_wdata;

  // derived move and fielder signals
  logic               obj_ok;
  logic               new_ok;
  logic [7:0]         new_loc;
  logic [7:0]         old_loc;
  logic               old_ok;
  logic [OBJECTS-1:0] obj_bit;
  logic [3:0]         f_col;
  logic [3:0]         f_row;
  logic               f_ok;
  logic [OBJECTS-1:0] f_bit;
  logic               hit;
  logic               in_fire;
  logic               out_full;
  logic               emit;

  // result words
  logic [7:0]  col_onehot;
  logic [15:0] acc_wide;
  logic [7:0]  zone_green;
  logic [7:0]  zone_rows_w;
  logic [47:0] res_data;
  logic [4:0]  res_user;

  function automatic logic [AW-1:0] cell_addr(input logic [3:0] c, input logic [3:0] r);
    logic [7:0] a;
    a = {4'b0, c} * 8'(ROWS) + {4'b0, r};
    return AW'(a);
  endfunction

  blmos_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl)
  );

  blmos_cell_mem #(
    .CELLS (CELLS),
    .AW    (AW),
    .WIDTH (OBJECTS)
  ) u_mem (
    .clk   (clk),
    .rst   (rst),
    .raddr (mem_raddr),
    .rdata (mem_rdata),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata)
  );

  assign s_tready = (ctrl.act == blmos_pkg::ACT_ACCEPT);
  assign in_fire  = s_tvalid && s_tready;
  assign out_full = m_tvalid && !m_tready;
  assign emit     = (ctrl.act == blmos_pkg::ACT_EMIT) && !out_full;

  // Decode the move target, the object's previous cell, the fielder cell and the scan hit
  always_comb begin
    obj_ok  = {1'b0, obj} < 5'(OBJECTS);
    new_ok  = obj_ok && ({1'b0, col} < 5'(COLUMNS)) && ({1'b0, row} < 5'(ROWS));
    new_loc = {col, row};
    old_loc = obj_ok ? loc[obj[OW-1:0]] : 8'h00;
    old_ok  = ({1'b0, old_loc[7:4]} < 5'(COLUMNS)) && ({1'b0, old_loc[3:0]} < 5'(ROWS));
    obj_bit = OBJECTS'(1) << obj;
    f_col   = blmos_pkg::fielder_col(cnt);
    f_row   = blmos_pkg::fielder_row(cnt);
    f_ok    = ({1'b0, cnt} < 5'(OBJECTS)) && ({1'b0, f_col} < 5'(COLUMNS))
              && ({1'b0, f_row} < 5'(ROWS));
    f_bit   = OBJECTS'(1) << cnt;
    hit     = |(mem_rdata & ((scan_state == blmos_pkg::ST_RED) ? RED_SEL : GREEN_SEL));
  end

  // Status for the jump conditions
  always_comb begin
    flags.no_input   = !s_tvalid;
    flags.is_tick    = (cmd == blmos_pkg::CMD_TICK);
    flags.is_move    = (cmd == blmos_pkg::CMD_MOVE);
    flags.move_skip  = !new_ok || (old_loc == new_loc);
    flags.ph_init    = (scan_state == blmos_pkg::ST_INIT);
    flags.ph_pause   = (scan_state == blmos_pkg::ST_PAUSE);
    flags.cnt_more   = (cnt != 4'(ROWS - 1));
    flags.field_more = (cnt != 4'(blmos_pkg::FIELDERS - 1));
    flags.out_full   = out_full;
  end

  // Drive the cell memory port from the current operation
  always_comb begin
    mem_raddr = '0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    case (ctrl.act)
      blmos_pkg::ACT_RD_OLD: begin
        mem_raddr = old_ok ? cell_addr(old_loc[7:4], old_loc[3:0]) : '0;
      end
      blmos_pkg::ACT_WR_OLD: begin
        mem_we    = old_ok;
        mem_waddr = old_ok ? cell_addr(old_loc[7:4], old_loc[3:0]) : '0;
        mem_wdata = mem_rdata & ~obj_bit;
      end
      blmos_pkg::ACT_RD_NEW: begin
        mem_raddr = cell_addr(col, row);
      end
      blmos_pkg::ACT_WR_NEW: begin
        mem_we    = (dur != 8'h00);
        mem_waddr = cell_addr(col, row);
        mem_wdata = mem_rdata | obj_bit;
      end
      blmos_pkg::ACT_RD_SCAN: begin
        mem_raddr = cell_addr({1'b0, scan_column}, cnt);
      end
      blmos_pkg::ACT_RD_FIELD: begin
        mem_raddr = f_ok ? cell_addr(f_col, f_row) : '0;
      end
      blmos_pkg::ACT_WR_FIELD: begin
        mem_we    = f_ok;
        mem_waddr = f_ok ? cell_addr(f_col, f_row) : '0;
        mem_wdata = mem_rdata | f_bit;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Next scan phase
  always_comb begin
    case (scan_state)
      blmos_pkg::ST_INIT:  scan_state_next = blmos_pkg::ST_RED;
      blmos_pkg::ST_RED:   scan_state_next = blmos_pkg::ST_PAUSE;
      blmos_pkg::ST_PAUSE: scan_state_next = blmos_pkg::ST_GREEN;
      blmos_pkg::ST_GREEN: scan_state_next = blmos_pkg::ST_RED;
      default:             scan_state_next = blmos_pkg::ST_INIT;
    endcase
  end

  // Hold the accepted command
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd <= s_tuser;
      obj <= s_tdata[3:0];
      col <= s_tdata[7:4];
      row <= s_tdata[11:8];
      dur <= s_tdata[19:12];
    end
  end

  // Object locations
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < OBJECTS; i++) begin
        loc[i] <= 8'h00;
      end
    end else if (ctrl.act == blmos_pkg::ACT_WR_NEW) begin
      loc[obj[OW-1:0]] <= new_loc;
    end else if (ctrl.act == blmos_pkg::ACT_WR_FIELD && f_ok) begin
      loc[cnt[OW-1:0]] <= {f_col, f_row};
    end
  end

  // Scan phase, column and zone LED
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_state  <= blmos_pkg::ST_BOOT;
      scan_column <= 3'd0;
      zone_cell   <= 9'd0;
    end else begin
      if (ctrl.act == blmos_pkg::ACT_PHASE) begin
        scan_state <= scan_state_next;
      end
      if (ctrl.act == blmos_pkg::ACT_ZONE && cmd == blmos_pkg::CMD_ZONE) begin
        zone_cell <= {(|{col, row, dur}), col, row};
      end
      if (emit && scan_state == blmos_pkg::ST_GREEN) begin
        scan_column <= (scan_column == 3'(COLUMNS - 1)) ? 3'd0 : scan_column + 3'd1;
      end
    end
  end

  // Loop counter and row accumulator
  always_ff @(posedge clk) begin
    case (ctrl.act)
      blmos_pkg::ACT_PHASE: begin
        cnt <= 4'd0;
        acc <= '0;
      end
      blmos_pkg::ACT_ACC: begin
        cnt <= cnt + 4'd1;
        acc <= acc | (hit ? (ROWS'(1) << cnt) : '0);
      end
      blmos_pkg::ACT_WR_FIELD: begin
        cnt <= cnt + 4'd1;
      end
      default: begin
        cnt <= cnt;
      end
    endcase
  end

  // Result words of the current phase
  always_comb begin
    col_onehot  = 8'(1) << scan_column;
    acc_wide    = 16'(acc);
    zone_green  = (zone_cell[8] && !zone_cell[7]) ? (8'(1) << zone_cell[6:4]) : 8'h00;
    zone_rows_w = (zone_cell[8] && !zone_cell[3]) ? ~(8'(1) << zone_cell[2:0]) : 8'hFF;
  end

  // Assemble the result item of the current phase
  always_comb begin
    res_data        = '0;
    res_data[46:39] = 8'hFF;
    res_user        = {blmos_pkg::phase_code(scan_state), 2'b00};
    case (scan_state)
      blmos_pkg::ST_INIT: begin
        res_user[1]  = 1'b1;
        res_data[47] = 1'b1;
      end
      blmos_pkg::ST_RED: begin
        res_data[9:5]   = col_onehot[4:0];
        res_data[22:10] = acc_wide[12:0];
        res_data[30:23] = zone_green;
        res_data[46:39] = zone_rows_w;
        res_data[47]    = 1'b1;
        res_user[1:0]   = 2'b11;
      end
      blmos_pkg::ST_GREEN: begin
        res_data[4:0]   = col_onehot[4:0];
        res_data[22:10] = acc_wide[12:0];
        res_data[47]    = 1'b1;
        res_user[0]     = 1'b1;
      end
      default: begin
        res_data[47] = 1'b0;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= res_data;
      m_tuser <= res_user;
    end
  end

  // The scan column never leaves the map
  a_column_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, scan_column} < 4'(COLUMNS))
    else $error("scan column outside map");

  // At most one field column is driven, in one color
  a_one_column: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot0(m_tdata[9:0]))
    else $error("more than one field column driven");

  // Field words are flagged only in red and green phases
  a_field_phase: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |->
      (m_tuser[4:2] == blmos_pkg::PH_RED || m_tuser[4:2] == blmos_pkg::PH_GREEN))
    else $error("field words flagged outside red or green phase");

endmodule

[tb/sv/tb_top.sv]
// Self-checking bench for the bicolor LED matrix object scanner: drives command items,
// predicts each tick's column, row and zone words, and checks every result item.
// Depends on blmos_pkg and bicolor_led_matrix_object_scanner.
`timescale 1ns / 1ps

module tb_top;

  localparam int N_COLS     = 5;
  localparam int N_ROWS     = 13;
  localparam int N_OBJS     = 14;
  localparam int RAND_ITEMS = 1330;
  localparam int MAX_CYCLES = 500000;
  localparam int TAIL_WAIT  = 60;

  // One command item as handed to the driver
  typedef struct packed {
    logic [1:0] cmd;
    logic [3:0] obj;
    logic [3:0] col;
    logic [3:0] row;
    logic [7:0] dur;
    logic       wait_drain;  // hold off until every pending tick result is back
  } cmd_item_t;

  // One tick result, split into its fields
  typedef struct packed {
    logic [4:0]  green_cols;
    logic [4:0]  red_cols;
    logic [12:0] rows;
    logic [7:0]  zone_green;
    logic [7:0]  zone_red;
    logic [7:0]  zone_rows;
    logic        field_written;
    logic        zone_written;
    logic        latch;
    logic [2:0]  phase;
  } scan_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;  // object_id[3:0], column[7:4], row[11:8], durations[19:12]
  logic [1:0]  s_tuser = '0;  // command[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // field_green_cols[4:0], field_red_cols[9:5], field_rows[22:10],
  // zone_green_cols[30:23], zone_red_cols[38:31], zone_rows[46:39], latch_strobe[47]
  logic [47:0] m_tdata;
  logic [4:0]  m_tuser;       // field_written[0], zone_written[1], phase[4:2]

  cmd_item_t  pending_cmds[$];
  scan_word_t expected_scans[$];
  int         total_cmds = 0;
  int         sent_count = 0;
  int         err_count = 0;
  int         cycle_count = 0;

  // Predicted block state
  logic [13:0] cell_map[N_COLS*N_ROWS];
  logic [7:0]  obj_loc[N_OBJS];
  logic [2:0]  scan_ph;
  logic [2:0]  scan_col;
  logic [8:0]  zone_cell;  // lit, column, row

  // Fielder home cells, column in the upper nibble
  const logic [7:0] fielder_home[9] = '{8'h26, 8'h2C, 8'h44, 8'h23, 8'h04,
                                        8'h13, 8'h01, 8'h21, 8'h41};

  bicolor_led_matrix_object_scanner dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #2 clk = ~clk;

  // Idle rates: sender light / receiver heavy, then swapped, then none
  function automatic int send_idle_pct();
    if (sent_count < total_cmds / 3) return 12;
    if (sent_count < 2 * total_cmds / 3) return 47;
    return 0;
  endfunction

  function automatic int recv_idle_pct();
    if (sent_count < total_cmds / 3) return 47;
    if (sent_count < 2 * total_cmds / 3) return 12;
    return 0;
  endfunction

  function automatic void add_cmd(input logic [1:0] cmd, input logic [3:0] obj,
                                  input logic [3:0] col, input logic [3:0] row,
                                  input logic [7:0] dur, input logic wait_drain = 1'b0);
    pending_cmds.push_back('{cmd, obj, col, row, dur, wait_drain});
  endfunction

  // Gather the rows of the scanned column that hold any object of the group
  function automatic logic [12:0] lit_rows(input logic [13:0] group);
    logic [12:0] r;
    r = '0;
    for (int k = 0; k < N_ROWS; k++)
      if ((cell_map[scan_col * N_ROWS + k] & group) != 0) r[k] = 1'b1;
    return r;
  endfunction

  // Advance the predicted state by one command; a tick queues its result
  function automatic void apply_command(input cmd_item_t c);
    scan_word_t w;
    logic [7:0] loc;
    logic [7:0] old;
    case (c.cmd)
      blmos_pkg::CMD_MOVE: begin
        if (c.obj < N_OBJS && c.col < N_COLS && c.row < N_ROWS) begin
          loc = {c.col, c.row};
          old = obj_loc[c.obj];
          if (old != loc) begin
            if (old[7:4] < N_COLS && old[3:0] < N_ROWS)
              cell_map[old[7:4] * N_ROWS + old[3:0]][c.obj] = 1'b0;
            if (c.dur != 0) cell_map[c.col * N_ROWS + c.row][c.obj] = 1'b1;
            obj_loc[c.obj] = loc;
          end
        end
      end
      blmos_pkg::CMD_ZONE: begin
        zone_cell = {((c.col | c.row | c.dur) != 0), c.col, c.row};
      end
      blmos_pkg::CMD_TICK: begin
        case (scan_ph)
          blmos_pkg::PH_INIT:  scan_ph = blmos_pkg::PH_RED;
          blmos_pkg::PH_RED:   scan_ph = blmos_pkg::PH_PAUSE;
          blmos_pkg::PH_PAUSE: scan_ph = blmos_pkg::PH_GREEN;
          blmos_pkg::PH_GREEN: scan_ph = blmos_pkg::PH_RED;
          default:             scan_ph = blmos_pkg::PH_INIT;
        endcase
        w = '0;
        w.zone_rows = 8'hFF;
        w.phase = scan_ph;
        case (scan_ph)
          blmos_pkg::PH_INIT: begin
            for (int k = 0; k < 9; k++) begin
              cell_map[fielder_home[k][7:4] * N_ROWS + fielder_home[k][3:0]][k] = 1'b1;
              obj_loc[k] = fielder_home[k];
            end
            w.zone_written = 1'b1;
            w.latch = 1'b1;
          end
          blmos_pkg::PH_RED: begin
            w.red_cols = 5'd1 << scan_col;
            w.rows = lit_rows(blmos_pkg::RED_MASK[13:0]);
            if (zone_cell[8]) begin
              if (zone_cell[7:4] < 8) w.zone_green = 8'd1 << zone_cell[7:4];
              if (zone_cell[3:0] < 8) w.zone_rows = ~(8'd1 << zone_cell[3:0]);
            end
            w.field_written = 1'b1;
            w.zone_written = 1'b1;
            w.latch = 1'b1;
          end
          blmos_pkg::PH_GREEN: begin
            w.green_cols = 5'd1 << scan_col;
            w.rows = lit_rows(blmos_pkg::GREEN_MASK[13:0]);
            w.field_written = 1'b1;
            w.latch = 1'b1;
            scan_col = (scan_col == N_COLS - 1) ? 3'd0 : scan_col + 3'd1;
          end
          default: ;
        endcase
        expected_scans.push_back(w);
      end
      default: ;
    endcase
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      err_count++;
    end
  endtask

  // Driver: present the head of the pending queue, predict on acceptance
  always @(posedge clk) begin : drive_cmds
    logic busy;
    cmd_item_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      busy = s_tvalid;
      if (s_tvalid && s_tready) begin
        apply_command(pending_cmds.pop_front());
        sent_count++;
        busy = 1'b0;
      end
      if (!busy) begin
        if (pending_cmds.size() > 0 &&
            !(pending_cmds[0].wait_drain && expected_scans.size() > 0) &&
            $urandom_range(99) >= send_idle_pct()) begin
          nxt = pending_cmds[0];
          s_tvalid <= 1'b1;
          s_tdata <= {4'b0, nxt.dur, nxt.row, nxt.col, nxt.obj};
          s_tuser <= nxt.cmd;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: take result items and compare them with the oldest prediction
  always @(posedge clk) begin : watch_results
    scan_word_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_scans.size() == 0) begin
          $error("result item with no tick pending: tdata %0h tuser %0h", m_tdata, m_tuser);
          err_count++;
        end else begin
          want = expected_scans.pop_front();
          check_field("field_green_cols", 16'(want.green_cols), 16'(m_tdata[4:0]));
          check_field("field_red_cols", 16'(want.red_cols), 16'(m_tdata[9:5]));
          check_field("field_rows", 16'(want.rows), 16'(m_tdata[22:10]));
          check_field("zone_green_cols", 16'(want.zone_green), 16'(m_tdata[30:23]));
          check_field("zone_red_cols", 16'(want.zone_red), 16'(m_tdata[38:31]));
          check_field("zone_rows", 16'(want.zone_rows), 16'(m_tdata[46:39]));
          check_field("latch_strobe", 16'(want.latch), 16'(m_tdata[47]));
          check_field("field_written", 16'(want.field_written), 16'(m_tuser[0]));
          check_field("zone_written", 16'(want.zone_written), 16'(m_tuser[1]));
          check_field("phase", 16'(want.phase), 16'(m_tuser[4:2]));
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct());
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= MAX_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int counted;
    int pick;
    cmd_item_t c;
    for (int k = 0; k < N_COLS * N_ROWS; k++) cell_map[k] = '0;
    for (int k = 0; k < N_OBJS; k++) obj_loc[k] = '0;
    scan_ph = blmos_pkg::PH_BOOT;
    scan_col = '0;
    zone_cell = '0;

    // Directed: ignored command, unlit zone, boot and init ticks, edge moves
    add_cmd(blmos_pkg::CMD_NOP, 4'hF, 4'hF, 4'hF, 8'hFF);
    add_cmd(blmos_pkg::CMD_ZONE, 4'h0, 4'h0, 4'h0, 8'h00);
    add_cmd(blmos_pkg::CMD_TICK, 4'h0, 4'h0, 4'h0, 8'h00);
    add_cmd(blmos_pkg::CMD_TICK, 4'h0, 4'h0, 4'h0, 8'h00);
    add_cmd(blmos_pkg::CMD_MOVE, 4'd0, 4'd4, 4'd12, 8'hFF);
    add_cmd(blmos_pkg::CMD_MOVE, 4'd13, 4'd0, 4'd0, 8'h01);  // same location: no change
    add_cmd(blmos_pkg::CMD_MOVE, 4'd13, 4'd3, 4'd7, 8'h10);
    add_cmd(blmos_pkg::CMD_MOVE, 4'd15, 4'd1, 4'd1, 8'hFF);  // unknown object
    add_cmd(blmos_pkg::CMD_MOVE, 4'd5, 4'd5, 4'd2, 8'hFF);   // column off the map
    add_cmd(blmos_pkg::CMD_MOVE, 4'd5, 4'd2, 4'd13, 8'hFF);  // row off the map
    add_cmd(blmos_pkg::CMD_MOVE, 4'd5, 4'd15, 4'd15, 8'hFF);
    add_cmd(blmos_pkg::CMD_MOVE, 4'd9, 4'd1, 4'd3, 8'h00);   // hidden object
    add_cmd(blmos_pkg::CMD_MOVE, 4'd10, 4'd0, 4'd12, 8'hF0);
    add_cmd(blmos_pkg::CMD_ZONE, 4'h0, 4'd7, 4'd0, 8'h00);
    add_cmd(blmos_pkg::CMD_TICK, 4'h0, 4'h0, 4'h0, 8'h00);   // red pause
    add_cmd(blmos_pkg::CMD_TICK, 4'h0, 4'h0, 4'h0, 8'h00);   // green
    add_cmd(blmos_pkg::CMD_ZONE, 4'hA, 4'd15, 4'd15, 8'hFF); // zone off the matrix
    add_cmd(blmos_pkg::CMD_TICK, 4'h0, 4'h0, 4'h0, 8'h00, 1'b1);
    add_cmd(blmos_pkg::CMD_ZONE, 4'h0, 4'd3, 4'd9, 8'h00);   // row off the matrix only
    add_cmd(blmos_pkg::CMD_TICK, 4'h0, 4'h0, 4'h0, 8'h00);
    add_cmd(blmos_pkg::CMD_ZONE, 4'h0, 4'd0, 4'd0, 8'h01);   // lit by durations alone
    add_cmd(blmos_pkg::CMD_TICK, 4'h0, 4'h0, 4'h0, 8'h00);
    add_cmd(blmos_pkg::CMD_TICK, 4'h0, 4'h0, 4'h0, 8'h00);

    // Random: mostly legal moves and ticks, some noise
    counted = 0;
    while (counted < RAND_ITEMS) begin
      c = '0;
      c.obj = 4'($urandom_range(15));
      c.col = 4'($urandom_range(15));
      c.row = 4'($urandom_range(15));
      c.dur = ($urandom_range(99) < 15) ? 8'h00 : 8'($urandom_range(255));
      pick = int'($urandom_range(99));
      if (pick < 40) begin
        c.cmd = blmos_pkg::CMD_TICK;
      end else if (pick < 80) begin
        c.cmd = blmos_pkg::CMD_MOVE;
        if ($urandom_range(99) < 90) begin
          c.obj = 4'($urandom_range(N_OBJS - 1));
          c.col = 4'($urandom_range(N_COLS - 1));
          c.row = 4'($urandom_range(N_ROWS - 1));
        end
      end else if (pick < 92) begin
        c.cmd = blmos_pkg::CMD_ZONE;
        if ($urandom_range(99) < 70) begin
          c.col = 4'($urandom_range(7));
          c.row = 4'($urandom_range(7));
        end
        if ($urandom_range(99) < 10) begin
          c.col = '0;
          c.row = '0;
          c.dur = '0;
        end
      end else begin
        c.cmd = blmos_pkg::CMD_NOP;
      end
      c.wait_drain = (counted == RAND_ITEMS / 2);
      pending_cmds.push_back(c);
      counted++;
    end
    total_cmds = pending_cmds.size();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() != 0 || expected_scans.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
